// ===== rtl/swam_pkg.sv =====
// ----------------------------------------------------------------------------
// swam_pkg
// Shared codes and types of the sliding window anagram matcher.
// ----------------------------------------------------------------------------
package swam_pkg;

    // item mode codes, carried in s_tuser
    localparam logic [1:0] MODE_CLEAR   = 2'd0;
    localparam logic [1:0] MODE_PATTERN = 2'd1;
    localparam logic [1:0] MODE_TEXT    = 2'd2;

    localparam int SYMBOL_W  = 5;
    // results held or in flight before the input side is held off
    localparam int RES_DEPTH = 4;

    typedef struct packed {
        logic pattern_overflow;
        logic found_so_far;
        logic window_match;
    } result_t;

endpackage

// ===== rtl/swam_ram.sv =====
// ----------------------------------------------------------------------------
// swam_ram
// Generic single write, single read RAM with a registered read port.
// ----------------------------------------------------------------------------
module swam_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 26,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/swam_cnt_mem.sv =====
// ----------------------------------------------------------------------------
// swam_cnt_mem
// Per-letter counter store: two read ports, one write port, per-entry valid
// bits that clear all entries at once, and bypass of the last write into the reads.
// ----------------------------------------------------------------------------
module swam_cnt_mem #(
    parameter int CW    = 9,
    parameter int DEPTH = 26,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          clr,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [CW-1:0] wdata,
    input  logic [AW-1:0] raddr_a,
    input  logic [AW-1:0] raddr_b,
    output logic [CW-1:0] rd_a,
    output logic [CW-1:0] rd_b
);

    logic [CW-1:0]    ram_a;
    logic [CW-1:0]    ram_b;
    logic [AW-1:0]    addr_a_reg;
    logic [AW-1:0]    addr_b_reg;
    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] valid_next;
    logic             lw_valid_reg;
    logic             lw_valid_next;
    logic [AW-1:0]    lw_addr_reg;
    logic [CW-1:0]    lw_data_reg;

    // one copy per read port, both written alike
    swam_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_ram_a (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr_a),
        .rdata (ram_a)
    );

    swam_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_ram_b (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr_b),
        .rdata (ram_b)
    );

    always_comb
    begin
        valid_next    = valid_reg;
        lw_valid_next = lw_valid_reg;
        if (clr)
        begin
            valid_next    = '0;
            lw_valid_next = 1'b0;
        end
        else if (we)
        begin
            valid_next[waddr] = 1'b1;
            lw_valid_next     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            lw_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            lw_valid_reg <= lw_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_a_reg <= raddr_a;
        addr_b_reg <= raddr_b;
        if (we)
        begin
            lw_addr_reg <= waddr;
            lw_data_reg <= wdata;
        end
    end

    // the RAM read that shared an edge with the last write saw stale data
    always_comb
    begin
        if (lw_valid_reg && (lw_addr_reg == addr_a_reg))
        begin
            rd_a = lw_data_reg;
        end
        else if (valid_reg[addr_a_reg])
        begin
            rd_a = ram_a;
        end
        else
        begin
            rd_a = '0;
        end

        if (lw_valid_reg && (lw_addr_reg == addr_b_reg))
        begin
            rd_b = lw_data_reg;
        end
        else if (valid_reg[addr_b_reg])
        begin
            rd_b = ram_b;
        end
        else
        begin
            rd_b = '0;
        end
    end

endmodule

// ===== rtl/swam_rfifo.sv =====
// ----------------------------------------------------------------------------
// swam_rfifo
// Small result queue between the update stage and the output channel.
// ----------------------------------------------------------------------------
module swam_rfifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  swam_pkg::result_t push_data,
    input  logic              pop,
    output logic              valid,
    output swam_pkg::result_t data
);

    localparam int DEPTH = swam_pkg::RES_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW    = $clog2(DEPTH + 1);

    swam_pkg::result_t slot_reg [DEPTH];
    logic [PW-1:0]     wptr_reg;
    logic [PW-1:0]     wptr_next;
    logic [PW-1:0]     rptr_reg;
    logic [PW-1:0]     rptr_next;
    logic [NW-1:0]     count_reg;
    logic [NW-1:0]     count_next;

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= push_data;
        end
    end

    assign valid = (count_reg != '0);
    assign data  = slot_reg[rptr_reg];

endmodule

// ===== rtl/sliding_window_anagram_matcher_core.sv =====
// ----------------------------------------------------------------------------
// sliding_window_anagram_matcher_core
// Streaming permutation search of a pattern over a letter stream.
// ----------------------------------------------------------------------------
// Input channel s_*: one item per handshake, s_tuser = mode (clear, append
// pattern letter, push text letter), s_tdata = letter index.
// Output channel m_*: exactly one result item per input item, in order:
// window match, sticky found flag, pattern overflow.
// Throughput is one item per cycle while s_tready stays high. An item passes
// the history read, then the counter read; the counter update then writes
// back and queues the result, which raises m_tvalid.
// The rate is set by the per-letter counter read-modify-write, which is done
// in a single stage with the previous item's write bypassed into the read.
// Window counts are held as separate add and remove tallies so that each
// text letter costs one write per counter store.
// Up to 4 items may be accepted and not yet delivered; with the receiver
// stalled, results queue and s_tready drops once 4 are outstanding, then
// rises again as results are taken.
// Reset (and a clear item) empty all counters at once through valid bits;
// no clearing pass is needed. The history store is never cleared, as only
// entries written since the last clear are read.
// ----------------------------------------------------------------------------
module sliding_window_anagram_matcher_core #(
    parameter int PATTERN_MAX = 256,
    parameter int ALPHABET    = 26
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [4:0] symbol, [7:5] zero
    input  logic [1:0] s_tuser,   // [1:0] mode
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] window_match, [1] found_so_far,
                                  // [2] pattern_overflow, [7:3] zero
);

    localparam int SYM_SPAN = 1 << swam_pkg::SYMBOL_W;
    localparam int ADEPTH   = (ALPHABET > SYM_SPAN) ? SYM_SPAN : ALPHABET;
    localparam int AW       = $clog2(ADEPTH);
    localparam int CW       = $clog2(PATTERN_MAX + 1);
    localparam int HW       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int MW       = $clog2(ADEPTH + 1);
    localparam int OW       = $clog2(swam_pkg::RES_DEPTH + 1);

    typedef struct packed {
        logic clr;
        logic app;
        logic ovf;
        logic push;
        logic pop;
        logic eq;
    } op_t;

    // ------------------------------------------------------------------
    // accept stage: scalar bookkeeping, history write and oldest read
    // ------------------------------------------------------------------
    logic                         in_acc;
    logic                         out_acc;
    logic [swam_pkg::SYMBOL_W-1:0] sym;
    logic                         sym_ok;
    logic [AW-1:0]                letter;
    op_t                          op;
    logic [CW-1:0]                plen_reg;
    logic [CW-1:0]                plen_next;
    logic [CW-1:0]                fill_reg;
    logic [CW-1:0]                fill_next;
    logic [HW-1:0]                hp_reg;
    logic [HW-1:0]                hp_next;
    logic [HW-1:0]                hp_inc;
    logic [CW:0]                  hp_ext;
    logic [CW:0]                  fill_ext;
    logic [CW:0]                  pos_wide;
    logic [HW-1:0]                pos;
    logic [AW-1:0]                hist_rdata;
    logic [OW-1:0]                outst_reg;
    logic [OW-1:0]                outst_next;

    assign in_acc  = s_tvalid && s_tready;
    assign s_tready = (outst_reg < OW'(swam_pkg::RES_DEPTH));
    assign sym     = s_tdata[swam_pkg::SYMBOL_W-1:0];
    assign sym_ok  = (32'(sym) < 32'(ALPHABET));
    assign letter  = sym[AW-1:0];

    assign hp_ext   = (CW+1)'(hp_reg);
    assign fill_ext = {1'b0, fill_reg};
    assign pos_wide = (hp_ext >= fill_ext) ? (hp_ext - fill_ext)
                                           : (hp_ext + (CW+1)'(PATTERN_MAX) - fill_ext);
    assign pos      = pos_wide[HW-1:0];
    assign hp_inc   = (hp_reg == HW'(PATTERN_MAX - 1)) ? '0 : hp_reg + 1'b1;

    always_comb
    begin
        op      = '0;
        op.clr  = (s_tuser == swam_pkg::MODE_CLEAR);
        op.ovf  = (s_tuser == swam_pkg::MODE_PATTERN) && sym_ok
                  && (plen_reg == CW'(PATTERN_MAX));
        op.app  = (s_tuser == swam_pkg::MODE_PATTERN) && sym_ok && !op.ovf;
        op.push = (s_tuser == swam_pkg::MODE_TEXT) && sym_ok && (plen_reg != '0);
        op.pop  = op.push && (fill_reg >= plen_reg);

        plen_next = plen_reg;
        fill_next = fill_reg;
        hp_next   = hp_reg;
        if (op.clr)
        begin
            plen_next = '0;
            fill_next = '0;
            hp_next   = '0;
        end
        else
        begin
            if (op.app)
            begin
                plen_next = plen_reg + 1'b1;
            end
            if (op.push)
            begin
                hp_next = hp_inc;
                if (!op.pop)
                begin
                    fill_next = fill_reg + 1'b1;
                end
            end
        end
        op.eq = (fill_next == plen_next);
    end

    always_comb
    begin
        outst_next = outst_reg;
        if (in_acc && !out_acc)
        begin
            outst_next = outst_reg + 1'b1;
        end
        else if (out_acc && !in_acc)
        begin
            outst_next = outst_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg  <= '0;
            fill_reg  <= '0;
            hp_reg    <= '0;
            outst_reg <= '0;
        end
        else
        begin
            outst_reg <= outst_next;
            if (in_acc)
            begin
                plen_reg <= plen_next;
                fill_reg <= fill_next;
                hp_reg   <= hp_next;
            end
        end
    end

    // oldest window letter sits fill places behind the write pointer
    swam_ram #(.WIDTH(AW), .DEPTH(PATTERN_MAX)) u_hist (
        .clk   (clk),
        .we    (in_acc && op.push),
        .waddr (hp_reg),
        .wdata (letter),
        .raddr (pos),
        .rdata (hist_rdata)
    );

    // ------------------------------------------------------------------
    // read stage: counter reads for the oldest letter and the new letter
    // ------------------------------------------------------------------
    logic          s1_valid_reg;
    op_t           s1_op_reg;
    logic [AW-1:0] s1_letter_reg;
    logic          s2_valid_reg;
    op_t           s2_op_reg;
    logic [AW-1:0] s2_letter_reg;
    logic [AW-1:0] s2_old_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_op_reg    <= '0;
            s2_valid_reg <= 1'b0;
            s2_op_reg    <= '0;
        end
        else
        begin
            s1_valid_reg <= in_acc;
            s1_op_reg    <= in_acc ? op : '0;
            s2_valid_reg <= s1_valid_reg;
            s2_op_reg    <= s1_op_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_letter_reg <= letter;
        s2_letter_reg <= s1_letter_reg;
        s2_old_reg    <= hist_rdata;
    end

    // ------------------------------------------------------------------
    // update stage: match bookkeeping and counter write back
    // ------------------------------------------------------------------
    logic [CW-1:0] pat_a;
    logic [CW-1:0] pat_b;
    logic [CW-1:0] add_a;
    logic [CW-1:0] add_b;
    logic [CW-1:0] sub_a;
    logic [CW-1:0] sub_b;
    logic [CW-1:0] win_a;
    logic [CW-1:0] win_b;
    logic [CW-1:0] win_c;
    logic [MW-1:0] matched_reg;
    logic [MW-1:0] matched_next;
    logic [MW-1:0] distinct_reg;
    logic [MW-1:0] distinct_next;
    logic          found_reg;
    logic          found_next;
    logic          match;
    logic          bef_o;
    logic          aft_o;
    logic          bef_c;
    logic          aft_c;
    logic          mem_clr;
    swam_pkg::result_t res;
    swam_pkg::result_t out_res;

    assign mem_clr = s2_valid_reg && s2_op_reg.clr;

    swam_cnt_mem #(.CW(CW), .DEPTH(ADEPTH)) u_pat (
        .clk     (clk),
        .rst_n   (rst_n),
        .clr     (mem_clr),
        .we      (s2_op_reg.app),
        .waddr   (s2_letter_reg),
        .wdata   (pat_b + 1'b1),
        .raddr_a (hist_rdata),
        .raddr_b (s1_letter_reg),
        .rd_a    (pat_a),
        .rd_b    (pat_b)
    );

    swam_cnt_mem #(.CW(CW), .DEPTH(ADEPTH)) u_add (
        .clk     (clk),
        .rst_n   (rst_n),
        .clr     (mem_clr),
        .we      (s2_op_reg.push),
        .waddr   (s2_letter_reg),
        .wdata   (add_b + 1'b1),
        .raddr_a (hist_rdata),
        .raddr_b (s1_letter_reg),
        .rd_a    (add_a),
        .rd_b    (add_b)
    );

    swam_cnt_mem #(.CW(CW), .DEPTH(ADEPTH)) u_sub (
        .clk     (clk),
        .rst_n   (rst_n),
        .clr     (mem_clr),
        .we      (s2_op_reg.pop),
        .waddr   (s2_old_reg),
        .wdata   (sub_a + 1'b1),
        .raddr_a (hist_rdata),
        .raddr_b (s1_letter_reg),
        .rd_a    (sub_a),
        .rd_b    (sub_b)
    );

    // window count = letters added minus letters dropped, modulo 2**CW
    assign win_a = add_a - sub_a;
    assign win_b = add_b - sub_b;

    always_comb
    begin
        matched_next  = matched_reg;
        distinct_next = distinct_reg;
        bef_o = 1'b0;
        aft_o = 1'b0;
        bef_c = 1'b0;
        aft_c = 1'b0;
        win_c = win_b;
        if (s2_op_reg.clr)
        begin
            matched_next  = '0;
            distinct_next = '0;
        end
        else if (s2_op_reg.app)
        begin
            bef_c = (pat_b != '0) && (win_b == pat_b);
            aft_c = (win_b == pat_b + 1'b1);
            distinct_next = distinct_reg + MW'(pat_b == '0);
            matched_next  = matched_reg - MW'(bef_c) + MW'(aft_c);
        end
        else if (s2_op_reg.push)
        begin
            if (s2_op_reg.pop)
            begin
                bef_o = (pat_a != '0) && (win_a == pat_a);
                aft_o = (pat_a != '0) && (win_a - 1'b1 == pat_a);
                // dropping the same letter first lowers its count
                win_c = win_b - CW'(s2_old_reg == s2_letter_reg);
            end
            bef_c = (pat_b != '0) && (win_c == pat_b);
            aft_c = (pat_b != '0) && (win_c + 1'b1 == pat_b);
            matched_next = matched_reg - MW'(bef_o) + MW'(aft_o)
                           - MW'(bef_c) + MW'(aft_c);
        end
        match      = s2_op_reg.eq && (matched_next == distinct_next);
        found_next = found_reg;
        if (s2_valid_reg)
        begin
            found_next = s2_op_reg.clr ? match : (found_reg || match);
        end
        res.window_match     = match;
        res.found_so_far     = found_next;
        res.pattern_overflow = s2_op_reg.ovf;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matched_reg  <= '0;
            distinct_reg <= '0;
            found_reg    <= 1'b0;
        end
        else
        begin
            matched_reg  <= matched_next;
            distinct_reg <= distinct_next;
            found_reg    <= found_next;
        end
    end

    // ------------------------------------------------------------------
    // result queue
    // ------------------------------------------------------------------
    assign out_acc = m_tvalid && m_tready;

    swam_rfifo u_rfifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s2_valid_reg),
        .push_data (res),
        .pop       (out_acc),
        .valid     (m_tvalid),
        .data      (out_res)
    );

    assign m_tdata = {5'd0, out_res};

endmodule

// ===== rtl/swam_checker.sv =====
// ----------------------------------------------------------------------------
// swam_checker
// Port-level checks of the matcher: output hold under stall, the bound on items
// accepted but not yet delivered, no result item with none outstanding, and input held off only when full.
// ----------------------------------------------------------------------------
module swam_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    localparam int OW = $clog2(swam_pkg::RES_DEPTH + 1) + 1;

    logic          in_acc;
    logic          out_acc;
    logic [OW-1:0] outst_reg;
    logic [OW-1:0] outst_next;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    always_comb
    begin
        outst_next = outst_reg + OW'(in_acc) - OW'(out_acc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outst_reg <= '0;
        end
        else
        begin
            outst_reg <= outst_next;
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    a_bound: assert property (@(posedge clk) disable iff (!rst_n)
        outst_reg <= OW'(swam_pkg::RES_DEPTH))
        else $error("too many items outstanding");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> outst_reg != '0)
        else $error("result item with no input item outstanding");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> outst_reg == OW'(swam_pkg::RES_DEPTH))
        else $error("input held off with room for results");

endmodule

bind sliding_window_anagram_matcher_core swam_checker u_swam_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
